// ===== hw/rtl/dbs_pkg.sv =====
// Shared types, codes and defaults for the deque and bag store.
package dbs_pkg;

	localparam int unsigned DEPTH_DEFAULT = 16;
	localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

	localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
	localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
	localparam logic [2:0] FN_POP_FRONT  = 3'd2;
	localparam logic [2:0] FN_POP_BACK   = 3'd3;
	localparam logic [2:0] FN_CONTAINS   = 3'd4;
	localparam logic [2:0] FN_REMOVE     = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [4:0]         entry_count;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
	} rsp_t;

	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic remove;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/deque_bag_store.sv =====
// Top level of the deque and bag store: control sequencer and the chain of cells.
// Each request beat passes an execute state to compare, shift and update the cell chain,
// then a result state to read the new front and back entries into the result register.
// A new request beat is taken in the same cycle that the previous result is loaded,
// and a stalled result side holds both.
// Reset clears the entry count and control state; cell contents stay undefined until written.
module deque_bag_store #(
	parameter int unsigned DEPTH = dbs_pkg::DEPTH_DEFAULT,
	parameter int unsigned VALUE_WIDTH = dbs_pkg::VALUE_WIDTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dbs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dbs_pkg::rsp_t rsp
);

	localparam int unsigned OCC_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(DEPTH);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_RESULT = 2'd2;

	logic [1:0]             state_q;
	logic [2:0]             func_s1;
	logic [VALUE_WIDTH-1:0] key_s1;
	logic [OCC_W-1:0]       occ_q;
	logic [OCC_W-1:0]       occ_next;
	logic [1:0]             status_q;
	logic [1:0]             status_next;
	logic                   found_q;
	logic                   found_next;
	logic                   rsp_valid_q;
	dbs_pkg::rsp_t          rsp_q;
	dbs_pkg::cell_ctrl_t    ctrl;

	logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
	logic                   hit [DEPTH+1];

	logic                   out_free;
	logic                   accept;
	logic                   full;
	logic                   empty;
	logic [OCC_W-1:0]       occ_m1;
	logic [VALUE_WIDTH-1:0] front_raw;
	logic [VALUE_WIDTH-1:0] back_raw;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == S_IDLE) || ((state_q == S_RESULT) && out_free));
	assign accept = req_valid && !req_stall;
	assign full = occ_q == OCC_W'(DEPTH);
	assign empty = occ_q == '0;

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_w;
		logic [VALUE_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = key_s1;
		end else begin : g_inner_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_inner_r
			assign right_w = cell_data[i+1];
		end

		dbs_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.OCC_W(OCC_W),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.occ(occ_q),
			.key(key_s1),
			.left_data(left_w),
			.right_data(right_w),
			.hit_in(hit[i]),
			.hit_out(hit[i+1]),
			.data(cell_data[i])
		);
	end

	always_comb begin
		ctrl = '0;
		occ_next = occ_q;
		status_next = dbs_pkg::ST_OK;
		found_next = 1'b0;
		if (state_q == S_EXEC) begin
			case (func_s1)
				dbs_pkg::FN_PUSH_FRONT, dbs_pkg::FN_PUSH_BACK: begin
					if (full) begin
						status_next = dbs_pkg::ST_FULL;
					end else begin
						ctrl.push_front = func_s1 == dbs_pkg::FN_PUSH_FRONT;
						ctrl.push_back = func_s1 == dbs_pkg::FN_PUSH_BACK;
						occ_next = occ_q + 1'b1;
					end
				end
				dbs_pkg::FN_POP_FRONT, dbs_pkg::FN_POP_BACK: begin
					if (empty) begin
						status_next = dbs_pkg::ST_EMPTY;
					end else begin
						ctrl.pop_front = func_s1 == dbs_pkg::FN_POP_FRONT;
						occ_next = occ_q - 1'b1;
					end
				end
				dbs_pkg::FN_CONTAINS: begin
					if (empty) begin
						status_next = dbs_pkg::ST_EMPTY;
					end else begin
						found_next = hit[DEPTH];
					end
				end
				dbs_pkg::FN_REMOVE: begin
					if (empty) begin
						status_next = dbs_pkg::ST_EMPTY;
					end else if (hit[DEPTH]) begin
						ctrl.remove = 1'b1;
						found_next = 1'b1;
						occ_next = occ_q - 1'b1;
					end else begin
						status_next = dbs_pkg::ST_MISSING;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign occ_m1 = occ_q - 1'b1;
	assign front_raw = empty ? '0 : cell_data[0];
	assign back_raw = empty ? '0 : cell_data[occ_m1[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			occ_q <= occ_next;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= accept ? S_EXEC : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((state_q == S_RESULT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			key_s1 <= VALUE_WIDTH'($unsigned(req.value));
		end
		if (state_q == S_EXEC) begin
			status_q <= status_next;
			found_q <= found_next;
		end
		if ((state_q == S_RESULT) && out_free) begin
			rsp_q.status <= status_q;
			rsp_q.found <= found_q;
			rsp_q.entry_count <= 5'(occ_q);
			rsp_q.front_value <= 32'(front_raw);
			rsp_q.back_value <= 32'(back_raw);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(DEPTH))
		else $error("Entry count exceeds the depth.");

	a_occ_change: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> ($past(state_q) == S_EXEC))
		else $error("Entry count changed outside the execute cycle.");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == S_RESULT))
		else $error("Result beat appeared without a result cycle.");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |-> !(found_q && (status_q != dbs_pkg::ST_OK)))
		else $error("A match was reported with a failing status.");

endmodule

// ===== hw/rtl/dbs_cell.sv =====
// One storage cell of the shift chain, with its compare and first-match carry.
module dbs_cell #(
	parameter int unsigned VALUE_WIDTH = dbs_pkg::VALUE_WIDTH_DEFAULT,
	parameter int unsigned OCC_W = 5,
	parameter int unsigned INDEX = 0
) (
	input  logic                   clk,
	input  dbs_pkg::cell_ctrl_t    ctrl,
	input  logic [OCC_W-1:0]       occ,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [VALUE_WIDTH-1:0] left_data,
	input  logic [VALUE_WIDTH-1:0] right_data,
	input  logic                   hit_in,
	output logic                   hit_out,
	output logic [VALUE_WIDTH-1:0] data
);

	logic [VALUE_WIDTH-1:0] data_q;
	logic                   occupied;
	logic                   match;

	assign occupied = OCC_W'(INDEX) < occ;
	assign match = occupied && (data_q == key);
	assign hit_out = hit_in | match;
	assign data = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			data_q <= left_data;
		end else if (ctrl.push_back && (occ == OCC_W'(INDEX))) begin
			data_q <= key;
		end else if (ctrl.pop_front || (ctrl.remove && hit_out)) begin
			data_q <= right_data;
		end
	end

endmodule
